### rtl/fpa_pkg.sv
// Package for the fixed-point ALU: opcodes, widths, default fraction bits and saturation limits.
// No dependencies.
`timescale 1ns / 1ps
package fpa_pkg;
  localparam int DataW = 32;
  localparam int FuncW = 4;
  localparam int FracBitsDefault = 8;

  localparam logic [FuncW-1:0] OP_ADD  = 4'd0;
  localparam logic [FuncW-1:0] OP_SUB  = 4'd1;
  localparam logic [FuncW-1:0] OP_MUL  = 4'd2;
  localparam logic [FuncW-1:0] OP_DIV  = 4'd3;
  localparam logic [FuncW-1:0] OP_GT   = 4'd4;
  localparam logic [FuncW-1:0] OP_LT   = 4'd5;
  localparam logic [FuncW-1:0] OP_GE   = 4'd6;
  localparam logic [FuncW-1:0] OP_LE   = 4'd7;
  localparam logic [FuncW-1:0] OP_EQ   = 4'd8;
  localparam logic [FuncW-1:0] OP_NE   = 4'd9;
  localparam logic [FuncW-1:0] OP_MIN  = 4'd10;
  localparam logic [FuncW-1:0] OP_MAX  = 4'd11;
  localparam logic [FuncW-1:0] OP_INC  = 4'd12;
  localparam logic [FuncW-1:0] OP_DEC  = 4'd13;
  localparam logic [FuncW-1:0] OP_TOI  = 4'd14;
  localparam logic [FuncW-1:0] OP_FRI  = 4'd15;

  localparam logic [DataW-1:0] RawMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] RawMin = 32'h8000_0000;

  // Item carried along the cell chain.
  typedef struct packed {
    logic             vld;
    logic [FuncW-1:0] func;
    logic [DataW-1:0] res;
    logic             cond;
    logic             err;
  } fpa_ctl_t;
endpackage

### rtl/fpa_if.sv
// Valid/ready channel interface carrying a parameterized payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface fpa_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fpa_cell.sv
// One step of the restoring divider chain: one quotient bit per cell.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_cell #(
  parameter int NW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  fpa_pkg::fpa_ctl_t ctl_in,
  input  logic [NW-1:0] rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [NW-1:0] den_in,
  input  logic [NW-1:0] quo_in,
  input  logic          neg_in,
  output fpa_pkg::fpa_ctl_t ctl_out,
  output logic [NW-1:0] rem_out,
  output logic [NW-1:0] num_out,
  output logic [NW-1:0] den_out,
  output logic [NW-1:0] quo_out,
  output logic          neg_out
);
  logic [NW:0] sh;
  logic [NW:0] df;
  assign sh = {rem_in, num_in[NW-1]};
  assign df = sh - {1'b0, den_in};

  // Advance one bit: shift remainder, try subtract. Drop the valid bit on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
      num_out <= {num_in[NW-2:0], 1'b0};
      den_out <= den_in;
      neg_out <= neg_in;
      if (!df[NW]) begin
        rem_out <= df[NW-1:0];
        quo_out <= {quo_in[NW-2:0], 1'b1};
      end else begin
        rem_out <= sh[NW-1:0];
        quo_out <= {quo_in[NW-2:0], 1'b0};
      end
    end
  end
endmodule

### rtl/fpa_front.sv
// Input stage: every operation but multiply and divide, plus divider/multiplier setup.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDefault,
  parameter int NW = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  logic [fpa_pkg::FuncW-1:0] func,
  input  logic signed [31:0]        operand_a,
  input  logic signed [31:0]        operand_b,
  output fpa_pkg::fpa_ctl_t         ctl,
  output logic [NW-1:0]             num,
  output logic [NW-1:0]             den,
  output logic                      neg,
  output logic signed [63:0]        prod
);
  logic signed [32:0] s_add, s_sub, s_inc, s_dec;
  logic signed [63:0] s_fri;
  logic [31:0] ma, mb;
  fpa_pkg::fpa_ctl_t c;

  function automatic logic [32:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) sat33 = {1'b1, fpa_pkg::RawMax};
    else if (v < -33'sh0_8000_0000) sat33 = {1'b1, fpa_pkg::RawMin};
    else sat33 = {1'b0, v[31:0]};
  endfunction

  always_comb begin
    s_add = 33'(operand_a) + 33'(operand_b);
    s_sub = 33'(operand_a) - 33'(operand_b);
    s_inc = 33'(operand_a) + 33'sd1;
    s_dec = 33'(operand_a) - 33'sd1;
    s_fri = 64'(operand_a) <<< FRAC_BITS;
    ma = operand_a[31] ? 32'(-operand_a) : operand_a;
    mb = operand_b[31] ? 32'(-operand_b) : operand_b;
    c = '0;
    c.vld = vld_in;
    c.func = func;
    case (func)
      fpa_pkg::OP_ADD: {c.err, c.res} = sat33(s_add);
      fpa_pkg::OP_SUB: {c.err, c.res} = sat33(s_sub);
      fpa_pkg::OP_INC: {c.err, c.res} = sat33(s_inc);
      fpa_pkg::OP_DEC: {c.err, c.res} = sat33(s_dec);
      fpa_pkg::OP_GT:  c.cond = operand_a > operand_b;
      fpa_pkg::OP_LT:  c.cond = operand_a < operand_b;
      fpa_pkg::OP_GE:  c.cond = operand_a >= operand_b;
      fpa_pkg::OP_LE:  c.cond = operand_a <= operand_b;
      fpa_pkg::OP_EQ:  c.cond = operand_a == operand_b;
      fpa_pkg::OP_NE:  c.cond = operand_a != operand_b;
      fpa_pkg::OP_MIN: c.res = (operand_a < operand_b) ? operand_a : operand_b;
      fpa_pkg::OP_MAX: c.res = (operand_a > operand_b) ? operand_a : operand_b;
      fpa_pkg::OP_TOI: c.res = 32'(operand_a >>> FRAC_BITS);
      fpa_pkg::OP_FRI: begin
        if (s_fri > 64'sh7FFF_FFFF) begin
          c.err = 1'b1; c.res = fpa_pkg::RawMax;
        end else if (s_fri < -64'sh8000_0000) begin
          c.err = 1'b1; c.res = fpa_pkg::RawMin;
        end else begin
          c.res = s_fri[31:0];
        end
      end
      fpa_pkg::OP_DIV: begin
        if (operand_b == 0) begin
          c.err = 1'b1;
          c.res = operand_a[31] ? fpa_pkg::RawMin : fpa_pkg::RawMax;
        end
      end
      default: c.res = '0;
    endcase
  end

  // Register the decoded item, the divide operands (2n+d over 2d) and product.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl <= c;
      num <= (NW'(ma) << (FRAC_BITS + 1)) + NW'(mb);
      den <= NW'(mb) << 1;
      neg <= operand_a[31] ^ operand_b[31];
      prod <= 64'(operand_a) * 64'(operand_b);
    end
  end
endmodule

### rtl/fixed_point_alu.sv
// Top level of the fixed-point ALU: front stage, divider cell chain, output stage.
// Depends on fpa_pkg, fpa_if, fpa_front and fpa_cell.
//
//  channel | dir | payload                             | handshake
//  req     | in  | func, operand_a, operand_b          | valid/ready
//  rsp     | out | result_raw, cond_true, error_flag   | valid/ready
//
// One request enters every cycle unless the pipe holds. Each result passes the
// front register, the NW-cell restoring divider chain (one quotient bit per
// cell) and the output register. The whole pipe advances together and holds
// when the output register is full and not taken. Reset clears only the valid
// bits; no request is taken while reset is high.
`timescale 1ns / 1ps
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input logic clk,
  input logic rst,
  fpa_if.sink   req,
  fpa_if.source rsp
);
  localparam int NW = 34 + FRAC_BITS;

  logic en;
  fpa_pkg::fpa_ctl_t ctl [NW+1];
  logic [NW-1:0] rem [NW+1];
  logic [NW-1:0] num [NW+1];
  logic [NW-1:0] den [NW+1];
  logic [NW-1:0] quo [NW+1];
  logic          neg [NW+1];
  logic signed [63:0] prod [NW+1];
  fpa_pkg::fpa_ctl_t ctl_f;
  logic [NW-1:0] num_f, den_f;
  logic neg_f;
  logic signed [63:0] prod_f;

  // Advance whenever the output slot is empty or being taken.
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en && !rst;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk(clk), .rst(rst), .en(en), .vld_in(req.valid),
    .func(req.data.func), .operand_a(req.data.operand_a),
    .operand_b(req.data.operand_b),
    .ctl(ctl_f), .num(num_f), .den(den_f), .neg(neg_f), .prod(prod_f)
  );

  // Feed the head of the chain.
  always_comb begin
    ctl[0] = ctl_f;
    rem[0] = '0;
    num[0] = num_f;
    den[0] = den_f;
    quo[0] = '0;
    neg[0] = neg_f;
    prod[0] = prod_f;
  end

  for (genvar i = 0; i < NW; i++) begin : g_cell
    fpa_cell #(.NW(NW)) u_cell (
      .clk(clk), .rst(rst), .en(en), .ctl_in(ctl[i]), .rem_in(rem[i]),
      .num_in(num[i]), .den_in(den[i]), .quo_in(quo[i]), .neg_in(neg[i]),
      .ctl_out(ctl[i+1]), .rem_out(rem[i+1]), .num_out(num[i+1]),
      .den_out(den[i+1]), .quo_out(quo[i+1]), .neg_out(neg[i+1])
    );
    // Carry the product alongside the chain.
    always_ff @(posedge clk) begin
      if (en) prod[i+1] <= prod[i];
    end
  end

  // Final rounding of mul, and sign and saturation of mul and div.
  logic [63:0] pm, pr;
  logic pn;
  logic signed [64:0] sv;
  logic [31:0] res_o;
  logic err_o;
  fpa_pkg::fpa_ctl_t ce;
  always_comb begin
    ce = ctl[NW];
    pn = prod[NW][63];
    pm = pn ? 64'(-prod[NW]) : prod[NW];
    pr = 64'((65'(pm) + (65'(1) << FRAC_BITS >> 1)) >> FRAC_BITS);
    res_o = ce.res;
    err_o = ce.err;
    sv = '0;
    if (ce.func == fpa_pkg::OP_MUL) begin
      sv = pn ? -65'(pr) : 65'(pr);
    end else begin
      sv = neg[NW] ? -65'(quo[NW]) : 65'(quo[NW]);
    end
    if ((ce.func == fpa_pkg::OP_MUL) || (ce.func == fpa_pkg::OP_DIV && !ce.err)) begin
      if (sv > 65'sh0_7FFF_FFFF) begin
        res_o = fpa_pkg::RawMax; err_o = 1'b1;
      end else if (sv < -65'sh0_8000_0000) begin
        res_o = fpa_pkg::RawMin; err_o = 1'b1;
      end else begin
        res_o = sv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= ce.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.data.result_raw <= res_o;
      rsp.data.cond_true <= ce.cond;
      rsp.data.error_flag <= err_o;
    end
  end
endmodule
